@@ src/dens_pkg.sv @@
package dens_pkg;

  localparam int unsigned RetryWidth = 16;
  localparam logic [RetryWidth-1:0] RetryLimitReset = 16'd1000;

  typedef struct packed {
    logic        command;
    logic [1:0]  word_index;
    logic [63:0] data_word;
    logic        start_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  out_index;
    logic [63:0] nonce_word;
    logic        status;
    logic        last;
  } rsp_t;

  localparam logic [255:0] OrderN =
    256'hFFFFFFFF00000000FFFFFFFFFFFFFFFFBCE6FAADA7179E84F3B9CAC2FC632551;

  localparam logic [255:0] ShaIv =
    256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  // Message sources that the controller selects for each 64-byte block.
  typedef enum logic [3:0] {
    BlkIpad,      // K ^ 0x36 padding
    BlkOpad,      // K ^ 0x5c padding
    BlkSeedA,     // V | sep | x[0:30]
    BlkSeedB,     // x[31] | h1 mod n | pad, length 64+97
    BlkVPad,      // V | pad, length 64+32
    BlkVSep,      // V | 0x00 | pad, length 64+33
    BlkInner      // inner digest | pad, length 64+32
  } blk_e;

  // Destination of a finished HMAC.
  typedef enum logic [1:0] {
    DstK,
    DstV
  } dst_e;

  typedef enum logic [3:0] {
    StIdle,
    StReduce,
    StInit,
    StBlkStart,
    StBlkRun,
    StBlkDone,
    StCheck,
    StOut
  } state_e;

  typedef struct packed {
    logic       load_init;   // V = 0x01.., K = 0
    logic       reduce;      // h1 mod n into reduced hash
    logic       chain_iv;    // start a fresh hash chain
    logic       blk_start;   // load message schedule and working vars
    blk_e       blk_sel;
    logic       sep;         // separator byte for the seed blocks
    logic       blk_step;    // one compression round
    logic       blk_fold;    // add working vars into chain
    logic       save_inner;  // chain to inner digest
    logic       write_back;  // chain to K or V
    dst_e       dst;
    logic       clear;       // wipe K and V
  } cmd_t;

  typedef struct packed {
    logic round_last;  // round 63 in progress
    logic cand_ok;     // 1 <= V <= n-1
  } sts_t;

endpackage

@@ src/dens_datapath.sv @@
module dens_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  dens_pkg::req_t req_i,
  input  dens_pkg::cmd_t cmd_i,
  output dens_pkg::sts_t sts_o,
  output logic [255:0]  cand_o
);
  import dens_pkg::*;

  logic [255:0] key_q, hash_q, rh_q, v_q, k_q, chain_q, inner_q;
  logic [511:0] w_q, blk;
  logic [255:0] s_q;
  logic [5:0]   rnd_q;

  // Store writes, word 0 is the most significant.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      if (!req_i.command) key_q[255-64*req_i.word_index -: 64] <= req_i.data_word;
      else                hash_q[255-64*req_i.word_index -: 64] <= req_i.data_word;
    end
  end

  always_comb begin
    blk = '0;
    unique case (cmd_i.blk_sel)
      BlkIpad:  blk = {k_q ^ {32{8'h36}}, {32{8'h36}}};
      BlkOpad:  blk = {k_q ^ {32{8'h5c}}, {32{8'h5c}}};
      BlkSeedA: blk = {v_q, 7'd0, cmd_i.sep, key_q[255:8]};
      BlkSeedB: blk = {key_q[7:0], rh_q, 8'h80, 176'd0, 64'd1288};
      BlkVPad:  blk = {v_q, 8'h80, 184'd0, 64'd768};
      BlkVSep:  blk = {v_q, 8'h00, 8'h80, 176'd0, 64'd776};
      BlkInner: blk = {inner_q, 8'h80, 184'd0, 64'd768};
      default:  blk = '0;
    endcase
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, w1, w9, w14, s0, s1, wn;
  always_comb begin
    {a, b, c, d, e, f, g, h} = s_q;
    w0  = w_q[511:480];
    w1  = w_q[479:448];
    w9  = w_q[223:192];
    w14 = w_q[63:32];
    s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wn = w0 + s0 + w9 + s1;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
       + sha_k(rnd_q) + w0;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  logic [255:0] folded;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      folded[255-32*i -: 32] = chain_q[255-32*i -: 32] + s_q[255-32*i -: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (cmd_i.blk_start) begin
      rnd_q <= '0;
    end else if (cmd_i.blk_step) begin
      rnd_q <= rnd_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reduce) rh_q <= (hash_q >= OrderN) ? hash_q - OrderN : hash_q;
    if (cmd_i.chain_iv) chain_q <= ShaIv;
    if (cmd_i.blk_start) begin
      w_q <= blk;
      s_q <= cmd_i.chain_iv ? ShaIv : chain_q;
    end else if (cmd_i.blk_step) begin
      w_q <= {w_q[479:0], wn};
      s_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
    if (cmd_i.blk_fold) chain_q <= folded;
    if (cmd_i.save_inner) inner_q <= chain_q;
    if (cmd_i.load_init) begin
      v_q <= {32{8'h01}};
      k_q <= '0;
    end else if (cmd_i.clear) begin
      v_q <= '0;
      k_q <= '0;
    end else if (cmd_i.write_back) begin
      if (cmd_i.dst == DstK) k_q <= chain_q;
      else                   v_q <= chain_q;
    end
  end

  assign sts_o.round_last = (rnd_q == 6'd63);
  assign sts_o.cand_ok    = (v_q != '0) && (v_q < OrderN);
  assign cand_o           = v_q;
endmodule

@@ src/dens_ctrl.sv @@
module dens_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [dens_pkg::RetryWidth-1:0] retry_limit_i,
  input  dens_pkg::sts_t                sts_i,
  output dens_pkg::cmd_t                cmd_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  output logic [1:0]                    out_index_o,
  output logic                          ok_o
);
  import dens_pkg::*;

  // An HMAC is a program of blocks: ipad, message blocks, opad, inner digest.
  // Programs: 0 seed rounds to K; 2 V update; 3 re-key K with 0x00 separator.
  state_e state_q, state_d;
  logic [2:0] blk_q, blk_d;       // block within HMAC program
  logic [1:0] prog_q, prog_d;
  logic [2:0] hstep_q, hstep_d;   // position in the derivation
  logic [RetryWidth-1:0] tries_q, tries_d;
  logic [1:0] oidx_q, oidx_d;
  logic ok_q, ok_d;
  logic sep_q, sep_d;
  logic [2:0] nblk;

  // blocks: seed prog = ipad,seedA,seedB,opad,inner ; others ipad,msg,opad,inner
  assign nblk = (prog_q == 2'd0) ? 3'd5 : 3'd4;

  always_comb begin
    cmd_o = '0;
    cmd_o.sep = sep_q;
    cmd_o.dst = (prog_q == 2'd2) ? DstV : DstK;
    cmd_o.blk_sel = BlkIpad;
    unique case (prog_q)
      2'd0: unique case (blk_q)
        3'd0: cmd_o.blk_sel = BlkIpad;
        3'd1: cmd_o.blk_sel = BlkSeedA;
        3'd2: cmd_o.blk_sel = BlkSeedB;
        3'd3: cmd_o.blk_sel = BlkOpad;
        default: cmd_o.blk_sel = BlkInner;
      endcase
      default: unique case (blk_q)
        3'd0: cmd_o.blk_sel = BlkIpad;
        3'd1: cmd_o.blk_sel = (prog_q == 2'd3) ? BlkVSep : BlkVPad;
        3'd2: cmd_o.blk_sel = BlkOpad;
        default: cmd_o.blk_sel = BlkInner;
      endcase
    endcase
    unique case (state_q)
      StReduce:   cmd_o.reduce = 1'b1;
      StInit:     cmd_o.load_init = 1'b1;
      StBlkStart: begin
        cmd_o.blk_start = 1'b1;
        cmd_o.chain_iv  = (blk_q == 3'd0) || (blk_q == nblk - 3'd2);
        // The inner digest is saved as the opad block starts, while the
        // chain still holds it.
        cmd_o.save_inner = (blk_q == nblk - 3'd2);
      end
      StBlkRun:   cmd_o.blk_step = 1'b1;
      StBlkDone:  cmd_o.blk_fold = 1'b1;
      StCheck:    cmd_o.write_back = 1'b1;
      StOut:      cmd_o.clear = (oidx_q == 2'd3);
      default: ;
    endcase
  end

  // hstep: 0 seed0 K,1 seed0 V,2 seed1 K,3 seed1 V,4 cand V,5 rekey K,6 rekey V
  always_comb begin
    state_d = state_q; blk_d = blk_q; prog_d = prog_q; hstep_d = hstep_q;
    tries_d = tries_q; oidx_d = oidx_q; ok_d = ok_q; sep_d = sep_q;
    unique case (state_q)
      StIdle: if (go_i) state_d = StReduce;
      StReduce: state_d = StInit;
      StInit: begin
        hstep_d = 3'd0; prog_d = 2'd0; sep_d = 1'b0; blk_d = '0;
        tries_d = '0; ok_d = 1'b0; oidx_d = '0;
        state_d = StBlkStart;
      end
      StBlkStart: state_d = StBlkRun;
      StBlkRun: if (sts_i.round_last) state_d = StBlkDone;
      StBlkDone: begin
        if (blk_q == nblk - 3'd1) state_d = StCheck;
        else begin
          blk_d = blk_q + 3'd1;
          state_d = StBlkStart;
        end
      end
      StCheck: begin
        blk_d = '0;
        state_d = StBlkStart;
        unique case (hstep_q)
          3'd0: begin hstep_d = 3'd1; prog_d = 2'd2; end
          3'd1: begin hstep_d = 3'd2; prog_d = 2'd0; sep_d = 1'b1; end
          3'd2: begin hstep_d = 3'd3; prog_d = 2'd2; end
          3'd5: begin hstep_d = 3'd6; prog_d = 2'd2; end
          default: begin
            // after seed V or re-key V: draw a candidate if tries remain; then check it
            if (hstep_q == 3'd4) begin
              // candidate is written in this cycle; checked in candidate branch
              hstep_d = 3'd7;
              state_d = StCheck;
            end else if (hstep_q == 3'd7) begin
              tries_d = tries_q + 1'b1;
              if (sts_i.cand_ok) begin
                ok_d = 1'b1; state_d = StOut;
              end else if (tries_q + 1'b1 == retry_limit_i) begin
                state_d = StOut;
              end else begin
                hstep_d = 3'd5; prog_d = 2'd3;
              end
            end else if (retry_limit_i == '0) begin
              state_d = StOut;
            end else begin
              hstep_d = 3'd4; prog_d = 2'd2;
            end
          end
        endcase
      end
      StOut: begin
        oidx_d = oidx_q + 2'd1;
        if (oidx_q == 2'd3) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; blk_q <= '0; prog_q <= '0; hstep_q <= '0;
      tries_q <= '0; oidx_q <= '0; ok_q <= 1'b0; sep_q <= 1'b0;
    end else begin
      state_q <= state_d; blk_q <= blk_d; prog_q <= prog_d; hstep_q <= hstep_d;
      tries_q <= tries_d; oidx_q <= oidx_d; ok_q <= ok_d; sep_q <= sep_d;
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_index_o = oidx_q;
  assign ok_o        = ok_q;
endmodule

@@ src/deterministic_ecdsa_nonce_unit.sv @@
// Deterministic ECDSA nonce unit (P-256, HMAC-SHA-256). Requests are taken
// when start is high and busy is low. A request with start_req clear only
// stores a key or hash word. A request with start_req set stores its word,
// then the block stays busy for the whole derivation and emits four result
// words, most significant first, in an unbroken burst with res_valid_o high;
// the receiver cannot stall and must take each one. All hashing runs through
// one SHA-256 round unit, one round per clock. The seed rounds need 18
// compressions, each candidate 4 more and each rejected candidate a further
// 8 for the re-key; a zero retry limit draws no candidate. The retry limit
// is written on the configuration channel only while the block is idle.
module deterministic_ecdsa_nonce_unit #(
  parameter logic [dens_pkg::RetryWidth-1:0] RetryReset = dens_pkg::RetryLimitReset
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  dens_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output dens_pkg::rsp_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dens_pkg::RetryWidth-1:0] cfg_data_i
);
  import dens_pkg::*;

  logic [RetryWidth-1:0] retry_q;
  logic accept, go, ok;
  logic [1:0] oidx;
  cmd_t cmd;
  sts_t sts;
  logic [255:0] cand;

  assign accept      = start && !busy;
  assign go          = accept && req_i.start_req;
  // The limit can only change while no derivation is running.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= RetryReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      retry_q <= cfg_data_i;
    end
  end

  dens_datapath u_dp (
    .clk_i, .rst_ni, .wr_i(accept), .req_i, .cmd_i(cmd), .sts_o(sts), .cand_o(cand)
  );

  dens_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .retry_limit_i(retry_q), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .out_valid_o(res_valid_o), .out_index_o(oidx), .ok_o(ok)
  );

  // The candidate is taken straight from V, which is cleared after the last word.
  always_comb begin
    res_o.out_index  = oidx;
    res_o.nonce_word = ok ? cand[255-64*oidx -: 64] : 64'd0;
    res_o.status     = !ok;
    res_o.last       = (oidx == 2'd3);
  end
endmodule

@@ src/dens_checker.sv @@
module dens_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input dens_pkg::req_t req_i,
  input logic           res_valid_o,
  input dens_pkg::rsp_t res_o
);
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result while idle");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o) else $error("result burst broken");
  a_zero_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status |-> res_o.nonce_word == 64'd0) else $error("bad fail word");
  a_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.start_req |=> busy) else $error("start not taken");
endmodule

bind deterministic_ecdsa_nonce_unit dens_checker u_chk (.*);
